[rtl/njt_pkg.sv]
`timescale 1ns / 1ps

package njt_pkg;

    localparam int MAX_TAXA   = 32;
    localparam int TAXA_BITS  = $clog2(MAX_TAXA);
    localparam int ID_BITS    = TAXA_BITS + 1;
    localparam int DIST_BITS  = 32;
    localparam int SUM_BITS   = 40;
    localparam int WIDE_BITS  = 44;
    localparam int ADDR_BITS  = 2 * ID_BITS;
    localparam int MEM_DEPTH  = 1 << ADDR_BITS;
    localparam int STEP_BITS  = $clog2(MAX_TAXA + 2);
    localparam int PASS_LAST  = MAX_TAXA + 1;
    localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);

    localparam logic [ID_BITS-1:0] TAXA_RESET = ID_BITS'(MAX_TAXA);
    localparam logic [ID_BITS-1:0] TAXA_MIN   = ID_BITS'(3);

    typedef logic [ID_BITS-1:0]          node_id_t;
    typedef logic signed [SUM_BITS-1:0]  row_sum_t;
    typedef logic signed [WIDE_BITS-1:0] wide_t;
    typedef logic signed [DIST_BITS-1:0] dist_t;

    typedef struct packed {
        node_id_t id;
        row_sum_t sum;
    } cell_word_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT1,
        CELL_SHIFT2,
        CELL_LOAD_ID,
        CELL_LOAD_SUM
    } cell_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_CHECK,
        S_SUM_LATCH,
        S_SUM_PASS,
        S_SUM_DIV,
        S_SUM_STORE,
        S_PAIR_LATCH,
        S_PAIR_PASS,
        S_PAIR_NEXT,
        S_JOIN0,
        S_JOIN1,
        S_EMIT_JOIN,
        S_COMPACT,
        S_NEW_RDP,
        S_NEW_RDQ,
        S_NEW_SUM,
        S_NEW_HALF,
        S_NEW_WR1,
        S_NEW_WR2,
        S_NEW_DIAG,
        S_FINAL_RD,
        S_FINAL_WAIT,
        S_EMIT_FINAL,
        S_EMIT_ERR
    } state_t;

    // halving, rounded toward zero
    function automatic wide_t half_tz(input wide_t x);
        wide_t t;
        begin
            t = x + {{(WIDE_BITS-1){1'b0}}, x[WIDE_BITS-1]};
            return t >>> 1;
        end
    endfunction

    // saturate a wide value to a distance word
    function automatic dist_t clamp_dist(input wide_t x);
        logic [WIDE_BITS-DIST_BITS:0] top;
        begin
            top = x[WIDE_BITS-1:DIST_BITS-1];
            if (top == '0 || top == '1)
                return x[DIST_BITS-1:0];
            else if (x[WIDE_BITS-1])
                return {1'b1, {(DIST_BITS-1){1'b0}}};
            else
                return {1'b0, {(DIST_BITS-1){1'b1}}};
        end
    endfunction

endpackage

[rtl/njt_cell.sv]
`timescale 1ns / 1ps

module njt_cell
    import njt_pkg::*;
(
    input  logic       clk,
    input  cell_op_t   op,
    input  cell_word_t nb1,
    input  cell_word_t nb2,
    input  node_id_t   id_in,
    input  row_sum_t   sum_in,
    output cell_word_t word
);

    cell_word_t word_reg;

    always_ff @(posedge clk)
    begin
        case (op)
            CELL_SHIFT1:   word_reg <= nb1;
            CELL_SHIFT2:   word_reg <= nb2;
            CELL_LOAD_ID:  word_reg.id <= id_in;
            CELL_LOAD_SUM: word_reg.sum <= sum_in;
            default:       word_reg <= word_reg;
        endcase
    end

    assign word = word_reg;

endmodule

[rtl/njt_div.sv]
`timescale 1ns / 1ps

module njt_div
    import njt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  row_sum_t             dividend,
    input  logic [TAXA_BITS-1:0] divisor,
    output logic                 done,
    output row_sum_t             quotient
);

    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic                    done_reg;
    logic [TAXA_BITS-1:0]    rem_reg;
    logic [SUM_BITS-1:0]     quo_reg;
    logic                    neg_reg;
    logic [TAXA_BITS-1:0]    dvs_reg;

    logic [TAXA_BITS:0]      rem_sh;
    logic                    ge;
    logic [TAXA_BITS:0]      rem_dif;

    assign rem_sh  = {rem_reg, quo_reg[SUM_BITS-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_dif = rem_sh - {1'b0, dvs_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= DIV_CNT_BITS'(SUM_BITS);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_BITS'(1))
                done_reg <= 1'b1;
        end
    end

    // restoring divide on magnitudes, one bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend[SUM_BITS-1] ? (SUM_BITS'(0) - dividend) : dividend;
            neg_reg <= dividend[SUM_BITS-1];
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[SUM_BITS-2:0], ge};
            rem_reg <= ge ? rem_dif[TAXA_BITS-1:0] : rem_sh[TAXA_BITS-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (SUM_BITS'(0) - quo_reg) : quo_reg;

endmodule

[rtl/neighbor_joining_tree_unit.sv]
`timescale 1ns / 1ps

// Neighbour-joining tree builder. Distance matrix words load one per cycle into
// a 64 x 64 distance memory; the word flagged last starts the build, during which
// no input is taken. Active nodes sit in a ring of 32 cells that rotates past a
// single memory read port for each pass over the active list. A round with n
// active nodes runs n row-sum passes, each followed by a bit-serial divide, n-1
// pair-search passes, a distance update for each remaining node, and a turn of
// the idle cells to bring the ring back into place. Results leave through an
// output register, so the next matrix may start loading while the last result
// waits to be taken.

module neighbor_joining_tree_unit
    import njt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [ID_BITS-1:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [TAXA_BITS-1:0] row,
    input  logic [TAXA_BITS-1:0] column,
    input  logic signed [DIST_BITS-1:0] distance,
    input  logic                 missing,
    input  logic                 last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ID_BITS-1:0]   left_node,
    output logic [ID_BITS-1:0]   right_node,
    output logic [ID_BITS-1:0]   new_node,
    output logic signed [DIST_BITS-1:0] left_length,
    output logic signed [DIST_BITS-1:0] right_length,
    output logic                 status,
    output logic                 last_join
);

    state_t state_reg, state_next;

    // configuration and taxon flags
    node_id_t              taxa_reg;
    logic [MAX_TAXA-1:0]   orphan_reg;

    // sequencer counters
    node_id_t              n_reg;
    logic [TAXA_BITS-1:0]  a_reg;
    logic [TAXA_BITS-1:0]  i_reg;
    logic [STEP_BITS-1:0]  stp_reg;
    logic [STEP_BITS-1:0]  k_reg;
    node_id_t              next_id_reg;

    // pass pipeline
    logic      s1_valid_reg, s2_valid_reg;
    node_id_t  s1_y_reg, s2_y_reg;
    row_sum_t  s1_ry_reg, s2_ry_reg;
    logic [TAXA_BITS-1:0] s1_pos_reg, s2_pos_reg;
    dist_t     s2_d_reg;
    wide_t     dv_reg;
    node_id_t  x_reg;
    row_sum_t  rx_reg;
    row_sum_t  acc_reg;

    // best pair
    logic      found_reg;
    wide_t     best_reg;
    node_id_t  p_reg, q_reg;
    logic [TAXA_BITS-1:0] pp_reg, pq_reg;
    dist_t     dpq_reg;
    row_sum_t  rp_reg, rq_reg;
    wide_t     t0_reg, t1_reg, e0_reg, e1_reg;

    // new distance
    dist_t     dp_reg;
    wide_t     ns_reg;
    dist_t     nv_reg;

    // distance memory
    logic [DIST_BITS-1:0] dist_mem [MEM_DEPTH];
    dist_t                rd_q;
    logic                 mem_we, mem_re;
    logic [ADDR_BITS-1:0] mem_waddr, mem_raddr;
    dist_t                mem_wdata;

    // output register
    logic      out_valid_reg;
    node_id_t  left_reg, right_reg, new_reg;
    dist_t     llen_reg, rlen_reg;
    logic      status_reg, last_join_reg;
    logic      out_free, out_load;
    node_id_t  ld_left, ld_right, ld_new;
    dist_t     ld_llen, ld_rlen;
    logic      ld_status, ld_last;
    wide_t     cor0, cor1;

    // cells
    cell_word_t cell_q  [MAX_TAXA];
    cell_op_t   cell_op [MAX_TAXA];
    node_id_t   cell_id_in;
    cell_word_t head, outer;

    logic      div_start, div_done;
    row_sum_t  div_q;

    logic      in_acc, issue_valid, rot_pass;
    node_id_t  w_cnt;
    node_id_t  cfg_v;

    assign in_acc    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign head      = cell_q[0];
    assign outer     = cell_q[a_reg];
    assign w_cnt     = n_reg - ID_BITS'(2);

    assign rot_pass = (state_reg == S_SUM_PASS || state_reg == S_PAIR_PASS) &&
                      (stp_reg < STEP_BITS'(MAX_TAXA));
    assign issue_valid = rot_pass && (stp_reg < STEP_BITS'(n_reg)) &&
                         (state_reg == S_SUM_PASS || stp_reg > STEP_BITS'(a_reg));

    // ---------------------------------------------------------------
    // cell ring: rotate for passes, close gaps after a join, append
    // ---------------------------------------------------------------
    assign cell_id_in = (state_reg == S_INIT) ? {1'b0, i_reg} : next_id_reg;

    for (genvar g = 0; g < MAX_TAXA; g++)
    begin : g_cell
        always_comb
        begin
            cell_op[g] = CELL_HOLD;
            unique case (state_reg)
                S_INIT:
                    if (!orphan_reg[i_reg] && n_reg == ID_BITS'(g))
                        cell_op[g] = CELL_LOAD_ID;
                S_SUM_STORE:
                    if (a_reg == TAXA_BITS'(g))
                        cell_op[g] = CELL_LOAD_SUM;
                S_SUM_PASS, S_PAIR_PASS:
                    if (rot_pass)
                        cell_op[g] = CELL_SHIFT1;
                S_NEW_RDP:
                    if (k_reg < STEP_BITS'(MAX_TAXA) && k_reg >= STEP_BITS'(w_cnt))
                        cell_op[g] = CELL_SHIFT1;
                S_NEW_WR2:
                    cell_op[g] = CELL_SHIFT1;
                S_COMPACT:
                    if (g + 1 >= int'(pq_reg))
                        cell_op[g] = CELL_SHIFT2;
                    else if (g >= int'(pp_reg))
                        cell_op[g] = CELL_SHIFT1;
                S_NEW_DIAG:
                    if (w_cnt == ID_BITS'(g))
                        cell_op[g] = CELL_LOAD_ID;
                default:
                    cell_op[g] = CELL_HOLD;
            endcase
        end

        njt_cell u_cell (
            .clk    (clk),
            .op     (cell_op[g]),
            .nb1    (cell_q[(g + 1) % MAX_TAXA]),
            .nb2    (cell_q[(g + 2) % MAX_TAXA]),
            .id_in  (cell_id_in),
            .sum_in (div_q),
            .word   (cell_q[g])
        );
    end

    njt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (w_cnt[TAXA_BITS-1:0]),
        .done     (div_done),
        .quotient (div_q)
    );

    assign div_start = (state_reg == S_SUM_PASS) && (stp_reg == STEP_BITS'(PASS_LAST));

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:       if (in_acc && last) state_next = S_INIT;
            S_INIT:       if ({1'b0, i_reg} == taxa_reg - ID_BITS'(1)) state_next = S_CHECK;
            S_CHECK:
                if (n_reg < ID_BITS'(2))
                    state_next = S_EMIT_ERR;
                else if (n_reg == ID_BITS'(2))
                    state_next = S_FINAL_RD;
                else
                    state_next = S_SUM_LATCH;
            S_SUM_LATCH:  state_next = S_SUM_PASS;
            S_SUM_PASS:   if (stp_reg == STEP_BITS'(PASS_LAST)) state_next = S_SUM_DIV;
            S_SUM_DIV:    if (div_done) state_next = S_SUM_STORE;
            S_SUM_STORE:
                if ({1'b0, a_reg} == n_reg - ID_BITS'(1))
                    state_next = S_PAIR_LATCH;
                else
                    state_next = S_SUM_LATCH;
            S_PAIR_LATCH: state_next = S_PAIR_PASS;
            S_PAIR_PASS:  if (stp_reg == STEP_BITS'(PASS_LAST)) state_next = S_PAIR_NEXT;
            S_PAIR_NEXT:
                if ({1'b0, a_reg} == w_cnt)
                    state_next = S_JOIN0;
                else
                    state_next = S_PAIR_LATCH;
            S_JOIN0:      state_next = S_JOIN1;
            S_JOIN1:      state_next = S_EMIT_JOIN;
            S_EMIT_JOIN:  if (out_free) state_next = S_COMPACT;
            S_COMPACT:    state_next = S_NEW_RDP;
            S_NEW_RDP:
                if (k_reg == STEP_BITS'(MAX_TAXA))
                    state_next = S_NEW_DIAG;
                else if (k_reg < STEP_BITS'(w_cnt))
                    state_next = S_NEW_RDQ;
            S_NEW_RDQ:    state_next = S_NEW_SUM;
            S_NEW_SUM:    state_next = S_NEW_HALF;
            S_NEW_HALF:   state_next = S_NEW_WR1;
            S_NEW_WR1:    state_next = S_NEW_WR2;
            S_NEW_WR2:    state_next = S_NEW_RDP;
            S_NEW_DIAG:   state_next = S_CHECK;
            S_FINAL_RD:   state_next = S_FINAL_WAIT;
            S_FINAL_WAIT: state_next = S_EMIT_FINAL;
            S_EMIT_FINAL: if (out_free) state_next = S_IDLE;
            S_EMIT_ERR:   if (out_free) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // memory port control and result word
    // ---------------------------------------------------------------
    // Kuhner-Felsenstein: a negative branch folds into its sibling
    always_comb
    begin
        if (e0_reg < 0)
        begin
            cor0 = '0;
            cor1 = e1_reg + e0_reg;
        end
        else if (e1_reg < 0)
        begin
            cor0 = e0_reg + e1_reg;
            cor1 = '0;
        end
        else
        begin
            cor0 = e0_reg;
            cor1 = e1_reg;
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {next_id_reg, head.id};
        mem_wdata = nv_reg;
        mem_re    = 1'b0;
        mem_raddr = {x_reg, head.id};
        out_load  = 1'b0;
        ld_left   = '0;
        ld_right  = '0;
        ld_new    = '0;
        ld_llen   = '0;
        ld_rlen   = '0;
        ld_status = 1'b0;
        ld_last   = 1'b0;
        unique case (state_reg)
            S_IDLE:
                if (in_acc)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = {1'b0, row, 1'b0, column};
                    mem_wdata = missing ? '0 : distance;
                end
            S_SUM_PASS, S_PAIR_PASS:
                mem_re = issue_valid;
            S_NEW_RDP:
            begin
                mem_re    = k_reg < STEP_BITS'(w_cnt);
                mem_raddr = {p_reg, head.id};
            end
            S_NEW_RDQ:
            begin
                mem_re    = 1'b1;
                mem_raddr = {q_reg, head.id};
            end
            S_NEW_WR1:
                mem_we = 1'b1;
            S_NEW_WR2:
            begin
                mem_we    = 1'b1;
                mem_waddr = {head.id, next_id_reg};
            end
            S_NEW_DIAG:
            begin
                mem_we    = 1'b1;
                mem_waddr = {next_id_reg, next_id_reg};
                mem_wdata = '0;
            end
            S_FINAL_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = {cell_q[0].id, cell_q[1].id};
            end
            S_EMIT_JOIN:
            begin
                out_load = out_free;
                ld_left  = p_reg;
                ld_right = q_reg;
                ld_new   = next_id_reg + ID_BITS'(1);
                ld_llen  = clamp_dist(cor0);
                ld_rlen  = clamp_dist(cor1);
            end
            S_EMIT_FINAL:
            begin
                out_load = out_free;
                ld_left  = cell_q[0].id;
                ld_right = cell_q[1].id;
                ld_llen  = rd_q;
                ld_rlen  = rd_q;
                ld_last  = 1'b1;
            end
            S_EMIT_ERR:
            begin
                out_load  = out_free;
                ld_status = 1'b1;
                ld_last   = 1'b1;
            end
            default:
                mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            dist_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_q <= $signed(dist_mem[mem_raddr]);
    end

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_comb
    begin
        cfg_v = cfg_data;
        if (cfg_v < TAXA_MIN)
            cfg_v = TAXA_MIN;
        else if (cfg_v > ID_BITS'(MAX_TAXA))
            cfg_v = ID_BITS'(MAX_TAXA);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            taxa_reg      <= TAXA_RESET;
            orphan_reg    <= '0;
            n_reg         <= '0;
            a_reg         <= '0;
            i_reg         <= '0;
            stp_reg       <= '0;
            k_reg         <= '0;
            next_id_reg   <= '0;
            found_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= issue_valid;
            s2_valid_reg <= s1_valid_reg;

            if (cfg_valid && cfg_ready)
                taxa_reg <= cfg_v;

            if (in_acc && ({1'b0, column} == taxa_reg - ID_BITS'(1)))
                orphan_reg[row] <= missing;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                    if (in_acc && last)
                    begin
                        n_reg       <= '0;
                        i_reg       <= '0;
                        next_id_reg <= taxa_reg - ID_BITS'(1);
                    end
                S_INIT:
                begin
                    i_reg <= i_reg + 1'b1;
                    if (!orphan_reg[i_reg])
                        n_reg <= n_reg + ID_BITS'(1);
                end
                S_CHECK:
                    a_reg <= '0;
                S_SUM_LATCH, S_PAIR_LATCH:
                    stp_reg <= '0;
                S_SUM_PASS, S_PAIR_PASS:
                    stp_reg <= stp_reg + 1'b1;
                S_SUM_STORE:
                    if ({1'b0, a_reg} == n_reg - ID_BITS'(1))
                    begin
                        a_reg     <= '0;
                        found_reg <= 1'b0;
                    end
                    else
                        a_reg <= a_reg + 1'b1;
                S_PAIR_NEXT:
                    a_reg <= a_reg + 1'b1;
                S_EMIT_JOIN:
                    if (out_free)
                        next_id_reg <= next_id_reg + ID_BITS'(1);
                S_COMPACT:
                    k_reg <= '0;
                S_NEW_RDP:
                    if (k_reg < STEP_BITS'(MAX_TAXA) && k_reg >= STEP_BITS'(w_cnt))
                        k_reg <= k_reg + 1'b1;
                S_NEW_WR2:
                    k_reg <= k_reg + 1'b1;
                S_NEW_DIAG:
                    n_reg <= n_reg - ID_BITS'(1);
                default:
                    n_reg <= n_reg;
            endcase

            if (state_reg == S_PAIR_PASS && s2_valid_reg &&
                (!found_reg || dv_reg < best_reg))
                found_reg <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        s1_y_reg   <= head.id;
        s1_ry_reg  <= head.sum;
        s1_pos_reg <= stp_reg[TAXA_BITS-1:0];
        s2_y_reg   <= s1_y_reg;
        s2_ry_reg  <= s1_ry_reg;
        s2_pos_reg <= s1_pos_reg;
        s2_d_reg   <= rd_q;
        dv_reg     <= WIDE_BITS'(rd_q) - WIDE_BITS'(rx_reg) - WIDE_BITS'(s1_ry_reg);

        if (state_reg == S_SUM_LATCH)
        begin
            x_reg   <= outer.id;
            acc_reg <= '0;
        end
        else if (state_reg == S_SUM_PASS && s1_valid_reg)
            acc_reg <= acc_reg + SUM_BITS'(rd_q);

        if (state_reg == S_PAIR_LATCH)
        begin
            x_reg  <= outer.id;
            rx_reg <= outer.sum;
        end

        // strict compare keeps the first pair on a tie
        if (state_reg == S_PAIR_PASS && s2_valid_reg && (!found_reg || dv_reg < best_reg))
        begin
            best_reg <= dv_reg;
            p_reg    <= x_reg;
            q_reg    <= s2_y_reg;
            pp_reg   <= a_reg;
            pq_reg   <= s2_pos_reg;
            dpq_reg  <= s2_d_reg;
            rp_reg   <= rx_reg;
            rq_reg   <= s2_ry_reg;
        end

        if (state_reg == S_JOIN0)
        begin
            t0_reg <= WIDE_BITS'(dpq_reg) + WIDE_BITS'(rp_reg);
            t1_reg <= WIDE_BITS'(dpq_reg) + WIDE_BITS'(rq_reg);
        end
        if (state_reg == S_JOIN1)
        begin
            e0_reg <= half_tz(t0_reg - WIDE_BITS'(rq_reg));
            e1_reg <= half_tz(t1_reg - WIDE_BITS'(rp_reg));
        end

        if (state_reg == S_NEW_RDQ)
            dp_reg <= rd_q;
        if (state_reg == S_NEW_SUM)
            ns_reg <= WIDE_BITS'(dp_reg) + WIDE_BITS'(rd_q) - WIDE_BITS'(dpq_reg);
        if (state_reg == S_NEW_HALF)
            nv_reg <= clamp_dist(half_tz(ns_reg));

        if (out_load)
        begin
            left_reg      <= ld_left;
            right_reg     <= ld_right;
            new_reg       <= ld_new;
            llen_reg      <= ld_llen;
            rlen_reg      <= ld_rlen;
            status_reg    <= ld_status;
            last_join_reg <= ld_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign left_node    = left_reg;
    assign right_node   = right_reg;
    assign new_node     = new_reg;
    assign left_length  = llen_reg;
    assign right_length = rlen_reg;
    assign status       = status_reg;
    assign last_join    = last_join_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_sum_needs_three: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM_PASS) |-> (n_reg >= ID_BITS'(3)))
        else $error("row-sum pass with fewer than three active nodes");

    a_div_in_place: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(div_done) |-> (state_reg == S_SUM_DIV))
        else $error("divider finished outside its wait state");

    a_pair_chosen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_JOIN0) |-> (found_reg && (pp_reg < pq_reg)))
        else $error("join without an ordered best pair");

    a_id_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_JOIN && out_free) |->
            (next_id_reg <= ID_BITS'(2 * MAX_TAXA - 4)))
        else $error("internal node id out of range");

endmodule

[bench/tb_neighbor_joining_tree_unit.sv]
`timescale 1ns / 1ps

// Bench for the neighbour-joining tree unit.
// Distance matrices go in one word at a time. A local tree builder follows
// every accepted word and predicts the join words of each build. The monitor
// pops those predictions in order and compares each output field.
//
// Every matrix writes each cell that the build will read: all pairs among the
// active taxa, diagonals included. It also writes one word into the reference
// column for every taxon below taxa_count, so that no orphan flag is left over
// from an earlier matrix.
// Inactive taxa are the ones whose reference-column word is flagged missing.
// This keeps the 32-taxon setting cheap: the tree is built over a few taxa only.

module tb_neighbor_joining_tree_unit;
    import njt_pkg::*;

    localparam int IDLE_LIMIT = 200000;   // well above the slowest round here
    localparam int DRAIN_GAP  = 60;

    typedef struct packed {
        logic [TAXA_BITS-1:0] row;
        logic [TAXA_BITS-1:0] column;
        logic signed [DIST_BITS-1:0] distance;
        logic                 missing;
        logic                 last;
    } entry_t;

    typedef struct packed {
        node_id_t left_id;
        node_id_t right_id;
        node_id_t joined_id;
        logic signed [31:0] left_len;
        logic signed [31:0] right_len;
        logic status_bit;
        logic last_bit;
    } join_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ID_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [TAXA_BITS-1:0] row = '0;
    logic [TAXA_BITS-1:0] column = '0;
    logic signed [DIST_BITS-1:0] distance = '0;
    logic missing = 1'b0;
    logic last = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [ID_BITS-1:0] left_node;
    logic [ID_BITS-1:0] right_node;
    logic [ID_BITS-1:0] new_node;
    logic signed [DIST_BITS-1:0] left_length;
    logic signed [DIST_BITS-1:0] right_length;
    logic status;
    logic last_join;

    neighbor_joining_tree_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .row          (row),
        .column       (column),
        .distance     (distance),
        .missing      (missing),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .left_node    (left_node),
        .right_node   (right_node),
        .new_node     (new_node),
        .left_length  (left_length),
        .right_length (right_length),
        .status       (status),
        .last_join    (last_join)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // Local tree builder: distance memory, orphan flags and taxa register
    // ---------------------------------------------------------------------
    longint dist_mem [64][64];
    longint row_avg [64];
    bit     orphan [32];
    int     taxa_cfg = MAX_TAXA;

    entry_t word_q [$];      // words waiting for the driver
    join_t  join_q [$];      // predicted join words, oldest first
    entry_t cur_word;
    int     gap_pct = 0;
    int     stall_pct = 0;
    int     err_count = 0;
    int     idle_cycles = 0;
    int     words_queued = 0;

    function automatic longint clamp_to(input longint x, input int bits);
        longint hi;
        longint lo;
        begin
            hi = (longint'(1) <<< (bits - 1)) - 1;
            lo = -hi - 1;
            if (x > hi) return hi;
            if (x < lo) return lo;
            return x;
        end
    endfunction

    task automatic push_join(input int l, input int r, input int nn, input longint ll,
                             input longint rl, input bit st, input bit lj);
        join_t j;
        begin
            j.left_id   = node_id_t'(l);
            j.right_id  = node_id_t'(r);
            j.joined_id = node_id_t'(nn);
            j.left_len  = 32'(clamp_to(ll, 32));
            j.right_len = 32'(clamp_to(rl, 32));
            j.status_bit = st;
            j.last_bit  = lj;
            join_q.push_back(j);
        end
    endtask

    // Store one accepted word; on the final word build the tree.
    task automatic build_tree(input entry_t e);
        int alist [64];
        int n;
        int nid;
        int p;
        int q;
        int w;
        int x;
        int y;
        bit found;
        longint s;
        longint best;
        longint dv;
        longint dpq;
        longint e0;
        longint e1;
        begin
            dist_mem[e.row][e.column] = e.missing ? 0 : longint'(e.distance);
            if (int'(e.column) == taxa_cfg - 1)
                orphan[e.row] = e.missing;
            if (!e.last)
                return;
            n = 0;
            for (int i = 0; i < taxa_cfg; i++)
                if (!orphan[i])
                begin
                    alist[n] = i;
                    n++;
                end
            nid = taxa_cfg - 1;
            if (n < 2)
            begin
                push_join(0, 0, 0, 0, 0, 1'b1, 1'b1);
                return;
            end
            while (n > 2)
            begin
                for (int a = 0; a < n; a++)
                begin
                    x = alist[a];
                    s = 0;
                    for (int b = 0; b < n; b++)
                        s += dist_mem[x][alist[b]];
                    row_avg[x] = clamp_to(s, SUM_BITS) / longint'(n - 2);
                end
                // first pair in list order wins a tie
                found = 1'b0;
                best = 0;
                p = 0;
                q = 0;
                for (int a = 0; a < n; a++)
                    for (int b = a + 1; b < n; b++)
                    begin
                        x = alist[a];
                        y = alist[b];
                        dv = dist_mem[x][y] - row_avg[x] - row_avg[y];
                        if (!found || dv < best)
                        begin
                            found = 1'b1;
                            best = dv;
                            p = x;
                            q = y;
                        end
                    end
                dpq = dist_mem[p][q];
                e0 = (dpq + row_avg[p] - row_avg[q]) / 2;
                e1 = (dpq + row_avg[q] - row_avg[p]) / 2;
                // negative branch: move its length onto the sibling
                if (e0 < 0)
                begin
                    e1 = e1 + e0;
                    e0 = 0;
                end
                else if (e1 < 0)
                begin
                    e0 = e0 + e1;
                    e1 = 0;
                end
                nid++;
                push_join(p, q, nid, e0, e1, 1'b0, 1'b0);
                w = 0;
                for (int a = 0; a < n; a++)
                    if (alist[a] != p && alist[a] != q)
                    begin
                        alist[w] = alist[a];
                        w++;
                    end
                n = w;
                for (int a = 0; a < n; a++)
                begin
                    x = alist[a];
                    dv = clamp_to((dist_mem[p][x] + dist_mem[q][x] - dpq) / 2, DIST_BITS);
                    dist_mem[nid][x] = dv;
                    dist_mem[x][nid] = dv;
                end
                dist_mem[nid][nid] = 0;
                alist[n] = nid;
                n++;
            end
            dv = dist_mem[alist[0]][alist[1]];
            push_join(alist[0], alist[1], 0, dv, dv, 1'b0, 1'b1);
        end
    endtask

    // ---------------------------------------------------------------------
    // Matrix generation
    // ---------------------------------------------------------------------
    function automatic logic [31:0] pick_dist(input int style);
        int r;
        begin
            r = $urandom_range(3);
            case (style)
                0: return $urandom_range(32'h0300_0000);
                1: return $urandom;
                2: return (r == 0) ? 32'h7FFF_FFFF : (r == 1) ? 32'h8000_0000 :
                          (r == 2) ? 32'hFFFF_FFFF : 32'h7FFF_0000;
                default: return '0;
            endcase
        end
    endfunction

    // style: 0 small positive, 1 full random, 2 extremes, 3 all zero (ties)
    task automatic queue_matrix(input int t, input int nact, input int style);
        bit     act [32];
        logic [31:0] dv [32][32];
        entry_t cells [$];
        entry_t e;
        entry_t tmp;
        int k;
        int j;
        begin
            for (int i = 0; i < 32; i++)
                act[i] = 1'b0;
            if (nact > t)
                nact = t;
            k = 0;
            while (k < nact)
            begin
                j = $urandom_range(t - 1);
                if (!act[j])
                begin
                    act[j] = 1'b1;
                    k++;
                end
            end
            for (int a = 0; a < t; a++)
                for (int b = a; b < t; b++)
                begin
                    dv[a][b] = (a == b && $urandom_range(3) != 0) ? '0 : pick_dist(style);
                    // mostly symmetric, now and then not
                    dv[b][a] = ($urandom_range(9) == 0) ? pick_dist(style) : dv[a][b];
                end
            for (int a = 0; a < t; a++)
            begin
                e = '0;
                e.row = TAXA_BITS'(a);
                if (act[a])
                begin
                    for (int b = 0; b < t; b++)
                        if (act[b])
                        begin
                            e.column = TAXA_BITS'(b);
                            e.distance = dv[a][b];
                            e.missing = (b != t - 1) && ($urandom_range(19) == 0);
                            cells.push_back(e);
                        end
                    if (!act[t - 1])
                    begin
                        e.column = TAXA_BITS'(t - 1);
                        e.distance = dv[a][t - 1];
                        e.missing = 1'b0;
                        cells.push_back(e);
                    end
                end
                else
                begin
                    // missing reference distance drops the taxon
                    e.column = TAXA_BITS'(t - 1);
                    e.distance = $urandom;
                    e.missing = 1'b1;
                    cells.push_back(e);
                end
            end
            // a few words outside the matrix in use
            if (t < 32)
                for (int i = $urandom_range(2); i > 0; i--)
                begin
                    e.row = TAXA_BITS'($urandom_range(31, t));
                    e.column = TAXA_BITS'($urandom_range(31, t));
                    e.distance = $urandom;
                    e.missing = $urandom_range(1);
                    cells.push_back(e);
                end
            for (int i = cells.size() - 1; i > 0; i--)
            begin
                j = $urandom_range(i);
                tmp = cells[i];
                cells[i] = cells[j];
                cells[j] = tmp;
            end
            cells[cells.size() - 1].last = 1'b1;
            foreach (cells[i])
                word_q.push_back(cells[i]);
            words_queued += cells.size();
        end
    endtask

    // ---------------------------------------------------------------------
    // Sequence helpers
    // ---------------------------------------------------------------------
    task automatic wait_drained();
        begin
            while (word_q.size() != 0 || in_valid || join_q.size() != 0)
                @(posedge clk);
            repeat (DRAIN_GAP) @(posedge clk);
        end
    endtask

    task automatic write_taxa(input int raw);
        int v;
        begin
            @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_data <= ID_BITS'(raw);
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
            v = raw & 63;
            if (v < 3) v = 3;
            if (v > MAX_TAXA) v = MAX_TAXA;
            taxa_cfg = v;
        end
    endtask

    // ---------------------------------------------------------------------
    // Driver: one word per handshake, random gaps between words
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                build_tree(cur_word);
            if (!in_valid || in_ready)
            begin
                if (word_q.size() != 0 && $urandom_range(99) >= gap_pct)
                begin
                    cur_word = word_q.pop_front();
                    row      <= cur_word.row;
                    column   <= cur_word.column;
                    distance <= cur_word.distance;
                    missing  <= cur_word.missing;
                    last     <= cur_word.last;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor and watchdog
    // ---------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        begin
            $display("%0t: join word %s got %0d want %0d", $realtime, what, got, want);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin
        join_t j;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (join_q.size() == 0)
                    report_mismatch("with nothing expected, left_node", left_node, -1);
                else
                begin
                    j = join_q.pop_front();
                    if (left_node != j.left_id)
                        report_mismatch("left_node", left_node, j.left_id);
                    if (right_node != j.right_id)
                        report_mismatch("right_node", right_node, j.right_id);
                    if (new_node != j.joined_id)
                        report_mismatch("new_node", new_node, j.joined_id);
                    if (left_length !== j.left_len)
                        report_mismatch("left_length", left_length, j.left_len);
                    if (right_length !== j.right_len)
                        report_mismatch("right_length", right_length, j.right_len);
                    if (status !== j.status_bit)
                        report_mismatch("status", status, j.status_bit);
                    if (last_join !== j.last_bit)
                        report_mismatch("last_join", last_join, j.last_bit);
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);

            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    initial
    begin
        int t;
        int nact;
        int sty;
        int grp;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: smallest matrix, ties, extremes, too few taxa, two taxa
        write_taxa(0);
        queue_matrix(3, 3, 3);
        queue_matrix(3, 3, 2);
        queue_matrix(3, 0, 0);
        queue_matrix(3, 1, 1);
        queue_matrix(3, 2, 0);
        wait_drained();
        // largest setting, sparse active set
        write_taxa(63);
        queue_matrix(32, 4, 1);
        wait_drained();
        write_taxa(32);
        queue_matrix(32, 5, 2);
        wait_drained();

        // random phases cycling through the idling patterns, each one at least once
        grp = 0;
        while (words_queued < 250 || grp < 4)
        begin
            case (grp % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 61; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 61; end
                default: begin gap_pct = 11; stall_pct = 11; end
            endcase
            write_taxa(($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(3, 12));
            t = taxa_cfg;
            nact = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 7);
            sty = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
            queue_matrix(t, nact, sty);
            wait_drained();
            grp++;
        end

        gap_pct = 0;
        stall_pct = 0;
        wait_drained();
        if (join_q.size() != 0)
            report_mismatch("count still pending", join_q.size(), 0);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/njt_pkg.sv
rtl/njt_cell.sv
rtl/njt_div.sv
rtl/neighbor_joining_tree_unit.sv
bench/tb_neighbor_joining_tree_unit.sv
